>>> rtl/core/tihc_pkg.sv
// Shared types and constants of the turn indicator and hazard controller.
// Depends on nothing; every other file of the block refers to it by scoped name.
package tihc_pkg;

  // Default width of the hold and blink timers.
  localparam int TimerBits = 16;

  // Fixed field widths.
  localparam int CfgWidth     = 16;
  localparam int ElapsedWidth = 8;
  localparam int EventWidth   = 6;

  // Configuration port geometry: two registers at byte addresses 0 and 4.
  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;

  // Register reset values.
  localparam logic [CfgWidth-1:0] LongPressReset     = 16'd1000;
  localparam logic [CfgWidth-1:0] BlinkIntervalReset = 16'd300;

  // Register indexes, selected by address bit 2.
  typedef enum logic [0:0] {
    RegLongPress     = 1'b0,
    RegBlinkInterval = 1'b1
  } reg_idx_e;

  // Bit positions in the event mask.
  localparam int EvLeftOn    = 0;
  localparam int EvLeftOff   = 1;
  localparam int EvRightOn   = 2;
  localparam int EvRightOff  = 3;
  localparam int EvHazardOn  = 4;
  localparam int EvHazardOff = 5;

  // Indicator flags as seen from one button: its own side, the other side, hazard.
  typedef struct packed {
    logic self_on;
    logic other_on;
    logic hazard_on;
  } side_flags_t;

  // Events that one button can raise in a step.
  typedef struct packed {
    logic turned_on;
    logic turned_off;
    logic hazard_off;
  } press_ev_t;

endpackage

>>> rtl/core/tihc_if.sv
// Valid/ready channel interfaces for the input steps and the result items.
// Depends on tihc_pkg for the field widths.
interface tihc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                left_pressed;
  logic                                right_pressed;
  logic [tihc_pkg::ElapsedWidth-1:0]   elapsed_ms;

  modport source (output valid, left_pressed, right_pressed, elapsed_ms, input ready);
  modport sink   (input valid, left_pressed, right_pressed, elapsed_ms, output ready);
endinterface

interface tihc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              left_lamp;
  logic                              right_lamp;
  logic                              hazard_active;
  logic                              left_selected;
  logic                              right_selected;
  logic [tihc_pkg::EventWidth-1:0]   event_mask;

  modport source (output valid, left_lamp, right_lamp, hazard_active, left_selected,
                  right_selected, event_mask, input ready);
  modport sink   (input valid, left_lamp, right_lamp, hazard_active, left_selected,
                  right_selected, event_mask, output ready);
endinterface

>>> rtl/core/tihc_cfg.sv
// APB-style configuration registers: long press threshold and blink interval.
// Depends on tihc_pkg for widths, reset values and register indexes.
module tihc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tihc_pkg::AddrWidth-1:0]   paddr,
  input  logic [tihc_pkg::DataWidth-1:0]   pwdata,
  output logic [tihc_pkg::DataWidth-1:0]   prdata,
  output logic                             pready,
  output logic [tihc_pkg::CfgWidth-1:0]    long_press_o,
  output logic [tihc_pkg::CfgWidth-1:0]    blink_interval_o
);

  logic [tihc_pkg::CfgWidth-1:0] long_press_q;
  logic [tihc_pkg::CfgWidth-1:0] blink_interval_q;
  tihc_pkg::reg_idx_e            reg_sel;
  logic                          wr_en;

  // Address bit 2 picks the register; the port never stalls.
  assign reg_sel = tihc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q     <= tihc_pkg::LongPressReset;
      blink_interval_q <= tihc_pkg::BlinkIntervalReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        tihc_pkg::RegLongPress:     long_press_q     <= pwdata[tihc_pkg::CfgWidth-1:0];
        tihc_pkg::RegBlinkInterval: blink_interval_q <= pwdata[tihc_pkg::CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_sel)
      tihc_pkg::RegLongPress:
        prdata = tihc_pkg::DataWidth'(long_press_q);
      tihc_pkg::RegBlinkInterval:
        prdata = tihc_pkg::DataWidth'(blink_interval_q);
      default:
        prdata = '0;
    endcase
  end

  assign long_press_o     = long_press_q;
  assign blink_interval_o = blink_interval_q;

endmodule

>>> rtl/core/tihc_button.sv
// Step logic for one button: hold measurement, long press detection and the
// resulting indicator or hazard change. Depends on tihc_pkg.
module tihc_button #(
  parameter int TimerBits = tihc_pkg::TimerBits
) (
  input  logic                                level_i,
  input  logic                                was_pressed_i,
  input  logic                                done_i,
  input  logic [TimerBits-1:0]                hold_i,
  input  logic [tihc_pkg::ElapsedWidth-1:0]   elapsed_i,
  input  logic [tihc_pkg::CfgWidth-1:0]       long_press_i,
  input  tihc_pkg::side_flags_t               flags_i,
  output logic [TimerBits-1:0]                hold_o,
  output logic                                done_o,
  output tihc_pkg::side_flags_t               flags_o,
  output tihc_pkg::press_ev_t                 ev_o
);

  localparam int CmpW = (TimerBits > tihc_pkg::CfgWidth) ? TimerBits : tihc_pkg::CfgWidth;

  logic [TimerBits:0]   hold_sum;
  logic [TimerBits-1:0] hold_next;
  logic                 fire;

  // Saturating hold time; a new press or a release starts again from zero.
  assign hold_sum  = {1'b0, hold_i} + (TimerBits+1)'(elapsed_i);
  assign hold_next = (level_i && was_pressed_i)
                   ? (hold_sum[TimerBits] ? {TimerBits{1'b1}} : hold_sum[TimerBits-1:0])
                   : '0;

  // A long press acts once until the button is released.
  assign fire = level_i && !done_i && (CmpW'(hold_next) >= CmpW'(long_press_i));

  assign hold_o = hold_next;
  assign done_o = level_i && (done_i || fire);

  // Long press clears hazard mode, or else toggles this side and clears the other.
  always_comb begin
    flags_o = flags_i;
    ev_o    = '0;
    if (fire) begin
      if (flags_i.hazard_on) begin
        flags_o.hazard_on = 1'b0;
        ev_o.hazard_off   = 1'b1;
      end else begin
        flags_o.self_on  = !flags_i.self_on;
        flags_o.other_on = 1'b0;
        ev_o.turned_on   = !flags_i.self_on;
        ev_o.turned_off  = flags_i.self_on;
      end
    end
  end

endmodule

>>> rtl/core/tihc_blink.sv
// Blink timer step: saturating interval count, phase flip and lamp latching.
// Depends on tihc_pkg for widths.
module tihc_blink #(
  parameter int TimerBits = tihc_pkg::TimerBits
) (
  input  logic [TimerBits-1:0]                timer_i,
  input  logic [tihc_pkg::ElapsedWidth-1:0]   elapsed_i,
  input  logic [tihc_pkg::CfgWidth-1:0]       interval_i,
  input  logic                                phase_i,
  input  logic                                hazard_i,
  input  logic                                left_on_i,
  input  logic                                right_on_i,
  input  logic                                left_lamp_i,
  input  logic                                right_lamp_i,
  output logic [TimerBits-1:0]                timer_o,
  output logic                                phase_o,
  output logic                                left_lamp_o,
  output logic                                right_lamp_o
);

  localparam int CmpW = (TimerBits > tihc_pkg::CfgWidth) ? TimerBits : tihc_pkg::CfgWidth;

  logic [TimerBits:0]   timer_sum;
  logic [TimerBits-1:0] timer_sat;
  logic                 flip;

  // Saturating timer; reaching the interval restarts it and drops the excess.
  assign timer_sum = {1'b0, timer_i} + (TimerBits+1)'(elapsed_i);
  assign timer_sat = timer_sum[TimerBits] ? {TimerBits{1'b1}} : timer_sum[TimerBits-1:0];
  assign flip      = CmpW'(timer_sat) >= CmpW'(interval_i);

  assign timer_o = flip ? '0 : timer_sat;
  assign phase_o = phase_i ^ flip;

  // Lamps follow the new phase at a flip and hold otherwise.
  assign left_lamp_o  = flip ? (phase_o && (hazard_i || left_on_i))  : left_lamp_i;
  assign right_lamp_o = flip ? (phase_o && (hazard_i || right_on_i)) : right_lamp_i;

endmodule

>>> rtl/core/turn_indicator_hazard_controller_core.sv
// Top level of the turn indicator and hazard controller: input register, step logic,
// state and result register. Depends on tihc_pkg, tihc_if, tihc_cfg, tihc_button, tihc_blink.

// Each input transfer is one time step carrying both button levels and the milliseconds
// elapsed since the previous step; each step yields exactly one result. The block takes
// one step per clock cycle while the output is not stalled: a step is held in the input
// register, evaluated by the combinational step logic (left button, right button, hazard
// check, blink timer) and lands in the result register, from which it leaves when the
// output is ready. A stalled result holds the pipeline; the input register then takes one
// more step only if it is empty. Register writes are meant for idle periods only. TIMER_BITS
// sets the width of the saturating hold and blink timers.
module turn_indicator_hazard_controller_core #(
  parameter int TIMER_BITS = tihc_pkg::TimerBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tihc_in_if.sink                          in_i,
  tihc_out_if.source                       out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tihc_pkg::AddrWidth-1:0]   paddr,
  input  logic [tihc_pkg::DataWidth-1:0]   pwdata,
  output logic [tihc_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  localparam int CmpW = (TIMER_BITS > tihc_pkg::CfgWidth) ? TIMER_BITS : tihc_pkg::CfgWidth;

  // Configuration.
  logic [tihc_pkg::CfgWidth-1:0] long_press;
  logic [tihc_pkg::CfgWidth-1:0] blink_interval;

  tihc_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .long_press_o     (long_press),
    .blink_interval_o (blink_interval)
  );

  // Input register and pipeline control.
  logic                                in_v_q;
  logic                                left_lvl_q;
  logic                                right_lvl_q;
  logic [tihc_pkg::ElapsedWidth-1:0]   elapsed_q;
  logic                                out_v_q;
  logic                                advance;
  logic                                step;

  assign advance    = !out_v_q || out_o.ready;
  assign in_i.ready = !in_v_q || advance;
  assign step       = in_v_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      left_lvl_q  <= in_i.left_pressed;
      right_lvl_q <= in_i.right_pressed;
      elapsed_q   <= in_i.elapsed_ms;
    end
  end

  // Controller state.
  logic [TIMER_BITS-1:0] left_hold_q, right_hold_q, blink_timer_q;
  logic                  left_done_q, right_done_q;
  logic                  left_was_q, right_was_q;
  logic                  left_on_q, right_on_q, hazard_q;
  logic                  phase_q, left_lamp_q, right_lamp_q;

  logic [TIMER_BITS-1:0] left_hold_d, right_hold_d, blink_timer_d;
  logic                  left_done_d, right_done_d;
  logic                  left_on_d, right_on_d, hazard_d;
  logic                  phase_d, left_lamp_d, right_lamp_d;
  logic [tihc_pkg::EventWidth-1:0] ev_d;

  // Left button sees the current flags.
  tihc_pkg::side_flags_t left_fl_in, left_fl_out;
  tihc_pkg::press_ev_t   left_ev;

  assign left_fl_in = '{self_on: left_on_q, other_on: right_on_q, hazard_on: hazard_q};

  tihc_button #(.TimerBits(TIMER_BITS)) u_left (
    .level_i       (left_lvl_q),
    .was_pressed_i (left_was_q),
    .done_i        (left_done_q),
    .hold_i        (left_hold_q),
    .elapsed_i     (elapsed_q),
    .long_press_i  (long_press),
    .flags_i       (left_fl_in),
    .hold_o        (left_hold_d),
    .done_o        (left_done_d),
    .flags_o       (left_fl_out),
    .ev_o          (left_ev)
  );

  // Right button sees the flags just updated by the left one.
  tihc_pkg::side_flags_t right_fl_in, right_fl_out;
  tihc_pkg::press_ev_t   right_ev;

  assign right_fl_in = '{self_on:   left_fl_out.other_on,
                         other_on:  left_fl_out.self_on,
                         hazard_on: left_fl_out.hazard_on};

  tihc_button #(.TimerBits(TIMER_BITS)) u_right (
    .level_i       (right_lvl_q),
    .was_pressed_i (right_was_q),
    .done_i        (right_done_q),
    .hold_i        (right_hold_q),
    .elapsed_i     (elapsed_q),
    .long_press_i  (long_press),
    .flags_i       (right_fl_in),
    .hold_o        (right_hold_d),
    .done_o        (right_done_d),
    .flags_o       (right_fl_out),
    .ev_o          (right_ev)
  );

  // Hazard check: both buttons held to at least the threshold while hazard is off.
  logic hazard_set;

  assign hazard_set = left_lvl_q && right_lvl_q && !right_fl_out.hazard_on
                   && (CmpW'(left_hold_d) >= CmpW'(long_press))
                   && (CmpW'(right_hold_d) >= CmpW'(long_press));

  assign hazard_d   = right_fl_out.hazard_on || hazard_set;
  assign left_on_d  = right_fl_out.other_on && !hazard_set;
  assign right_on_d = right_fl_out.self_on && !hazard_set;

  // Event mask gathers every event of the step.
  always_comb begin
    ev_d = '0;
    ev_d[tihc_pkg::EvLeftOn]    = left_ev.turned_on;
    ev_d[tihc_pkg::EvLeftOff]   = left_ev.turned_off;
    ev_d[tihc_pkg::EvRightOn]   = right_ev.turned_on;
    ev_d[tihc_pkg::EvRightOff]  = right_ev.turned_off;
    ev_d[tihc_pkg::EvHazardOn]  = hazard_set;
    ev_d[tihc_pkg::EvHazardOff] = left_ev.hazard_off || right_ev.hazard_off;
  end

  // Blink timer works on the final flags of the step.
  tihc_blink #(.TimerBits(TIMER_BITS)) u_blink (
    .timer_i      (blink_timer_q),
    .elapsed_i    (elapsed_q),
    .interval_i   (blink_interval),
    .phase_i      (phase_q),
    .hazard_i     (hazard_d),
    .left_on_i    (left_on_d),
    .right_on_i   (right_on_d),
    .left_lamp_i  (left_lamp_q),
    .right_lamp_i (right_lamp_q),
    .timer_o      (blink_timer_d),
    .phase_o      (phase_d),
    .left_lamp_o  (left_lamp_d),
    .right_lamp_o (right_lamp_d)
  );

  // State update once per evaluated step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hold_q   <= '0;
      right_hold_q  <= '0;
      left_done_q   <= 1'b0;
      right_done_q  <= 1'b0;
      left_was_q    <= 1'b0;
      right_was_q   <= 1'b0;
      left_on_q     <= 1'b0;
      right_on_q    <= 1'b0;
      hazard_q      <= 1'b0;
      phase_q       <= 1'b0;
      blink_timer_q <= '0;
      left_lamp_q   <= 1'b0;
      right_lamp_q  <= 1'b0;
    end else if (step) begin
      left_hold_q   <= left_hold_d;
      right_hold_q  <= right_hold_d;
      left_done_q   <= left_done_d;
      right_done_q  <= right_done_d;
      left_was_q    <= left_lvl_q;
      right_was_q   <= right_lvl_q;
      left_on_q     <= left_on_d;
      right_on_q    <= right_on_d;
      hazard_q      <= hazard_d;
      phase_q       <= phase_d;
      blink_timer_q <= blink_timer_d;
      left_lamp_q   <= left_lamp_d;
      right_lamp_q  <= right_lamp_d;
    end
  end

  // Result register.
  logic                            res_left_lamp_q, res_right_lamp_q, res_hazard_q;
  logic                            res_left_sel_q, res_right_sel_q;
  logic [tihc_pkg::EventWidth-1:0] res_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_left_lamp_q  <= left_lamp_d;
      res_right_lamp_q <= right_lamp_d;
      res_hazard_q     <= hazard_d;
      res_left_sel_q   <= left_on_d;
      res_right_sel_q  <= right_on_d;
      res_ev_q         <= ev_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.left_lamp      = res_left_lamp_q;
  assign out_o.right_lamp     = res_right_lamp_q;
  assign out_o.hazard_active  = res_hazard_q;
  assign out_o.left_selected  = res_left_sel_q;
  assign out_o.right_selected = res_right_sel_q;
  assign out_o.event_mask     = res_ev_q;

  // Hazard mode and a selected side never coexist.
  a_hazard_excludes_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hazard_q |-> (!left_on_q && !right_on_q))
    else $error("hazard mode active with an indicator selected");

  // At most one side is selected.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(res_left_sel_q && res_right_sel_q))
    else $error("both indicators selected");

  // A hazard-on event leaves hazard mode active in the same result.
  a_hazard_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && res_ev_q[tihc_pkg::EvHazardOn]) |-> res_hazard_q)
    else $error("hazard on event without hazard mode");

  // A step cannot both turn the left side on and off.
  a_left_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(res_ev_q[tihc_pkg::EvLeftOn] && res_ev_q[tihc_pkg::EvLeftOff]))
    else $error("left on and left off in one step");

endmodule

>>> dv/turn_indicator_hazard_controller_core_test.sv
// Self-checking testbench for the turn indicator and hazard controller core.
// Depends on tihc_pkg, tihc_if and the core RTL; it predicts every status item from
// the accepted steps and checks the results against it, with random stalls on both sides.
module turn_indicator_hazard_controller_core_test;

  localparam int HoldBits = tihc_pkg::TimerBits;
  localparam int CfgW     = tihc_pkg::CfgWidth;
  localparam int ElW      = tihc_pkg::ElapsedWidth;
  localparam int EvW      = tihc_pkg::EventWidth;
  localparam int AddrW    = tihc_pkg::AddrWidth;
  localparam int DataW    = tihc_pkg::DataWidth;

  // One status item as the core presents it, in port order.
  typedef struct packed {
    logic           left_lamp;
    logic           right_lamp;
    logic           hazard_active;
    logic           left_selected;
    logic           right_selected;
    logic [EvW-1:0] event_mask;
  } lamp_status_t;

  // Predicts the indicator state per step and holds the status items still owed.
  class indicator_tracker;
    logic [CfgW-1:0]     long_press_ms;
    logic [CfgW-1:0]     blink_interval_ms;
    logic [HoldBits-1:0] hold_ms [2];
    logic [HoldBits-1:0] blink_ms;
    bit                  was_down [2];
    bit                  press_taken [2];
    bit                  side_on [2];
    bit                  lamp [2];
    bit                  hazard;
    bit                  phase;
    lamp_status_t        expected_status_q [$];
    int                  mismatches;
    int                  checked;

    function new();
      long_press_ms     = tihc_pkg::LongPressReset;
      blink_interval_ms = tihc_pkg::BlinkIntervalReset;
      blink_ms          = '0;
      hazard            = 1'b0;
      phase             = 1'b0;
      mismatches        = 0;
      checked           = 0;
      for (int s = 0; s < 2; s++) begin
        hold_ms[s]     = '0;
        was_down[s]    = 1'b0;
        press_taken[s] = 1'b0;
        side_on[s]     = 1'b0;
        lamp[s]        = 1'b0;
      end
    endfunction

    function void set_reg(tihc_pkg::reg_idx_e idx, logic [CfgW-1:0] value);
      if (idx == tihc_pkg::RegLongPress) begin
        long_press_ms = value;
      end else begin
        blink_interval_ms = value;
      end
    endfunction

    function logic [HoldBits-1:0] sat_add(logic [HoldBits-1:0] a, logic [ElW-1:0] b);
      logic [HoldBits:0] sum;
      sum = {1'b0, a} + (HoldBits+1)'(b);
      return sum[HoldBits] ? '1 : sum[HoldBits-1:0];
    endfunction

    function void fail(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endfunction

    // Advance the prediction by one accepted step and queue the status it yields.
    function void take_step(bit left_down, bit right_down, logic [ElW-1:0] el);
      bit             down [2];
      logic [EvW-1:0] ev;
      lamp_status_t   st;
      int             other;
      down[0] = left_down;
      down[1] = right_down;
      ev      = '0;

      // A continuing press accumulates time; the first step of a press starts at zero.
      for (int s = 0; s < 2; s++) begin
        if (down[s] && was_down[s]) begin
          hold_ms[s] = sat_add(hold_ms[s], el);
        end
      end

      // Left button first, then right, each acting once per long press.
      for (int s = 0; s < 2; s++) begin
        other = 1 - s;
        if (down[s]) begin
          if (!was_down[s]) begin
            hold_ms[s] = '0;
          end
          if (!press_taken[s] && hold_ms[s] >= long_press_ms) begin
            if (hazard) begin
              hazard = 1'b0;
              ev[tihc_pkg::EvHazardOff] = 1'b1;
            end else begin
              side_on[s]     = !side_on[s];
              side_on[other] = 1'b0;
              if (s == 0) begin
                ev[side_on[s] ? tihc_pkg::EvLeftOn : tihc_pkg::EvLeftOff] = 1'b1;
              end else begin
                ev[side_on[s] ? tihc_pkg::EvRightOn : tihc_pkg::EvRightOff] = 1'b1;
              end
            end
            press_taken[s] = 1'b1;
          end
        end else begin
          hold_ms[s]     = '0;
          press_taken[s] = 1'b0;
        end
        was_down[s] = down[s];
      end

      // Both buttons held long enough turn hazard mode on.
      if (down[0] && down[1] && hold_ms[0] >= long_press_ms &&
          hold_ms[1] >= long_press_ms && !hazard) begin
        hazard     = 1'b1;
        side_on[0] = 1'b0;
        side_on[1] = 1'b0;
        ev[tihc_pkg::EvHazardOn] = 1'b1;
      end

      // The blink timer flips the phase and latches the lamps.
      blink_ms = sat_add(blink_ms, el);
      if (blink_ms >= blink_interval_ms) begin
        blink_ms = '0;
        phase    = !phase;
        for (int s = 0; s < 2; s++) begin
          lamp[s] = hazard ? phase : (side_on[s] && phase);
        end
      end

      st = {lamp[0], lamp[1], hazard, side_on[0], side_on[1], ev};
      expected_status_q.push_back(st);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        fail($sformatf("%s expected %0d, got %0d", name, want, got));
      end
    endfunction

    // Compare one accepted status transfer with the oldest prediction.
    function void compare_status(lamp_status_t got);
      lamp_status_t want;
      if (expected_status_q.size() == 0) begin
        fail("status transfer with no step outstanding");
        return;
      end
      want = expected_status_q.pop_front();
      checked++;
      check_field("left_lamp", want.left_lamp, got.left_lamp);
      check_field("right_lamp", want.right_lamp, got.right_lamp);
      check_field("hazard_active", want.hazard_active, got.hazard_active);
      check_field("left_selected", want.left_selected, got.left_selected);
      check_field("right_selected", want.right_selected, got.right_selected);
      check_field("event_mask", want.event_mask, got.event_mask);
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tihc_in_if  step_ch ();
  tihc_out_if status_ch ();

  indicator_tracker tracker = new();
  int               steps_sent = 0;
  int               burst_left = 1;
  int               settings = 1;

  turn_indicator_hazard_controller_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (step_ch),
    .out_o   (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: checks each status transfer and stalls in changing patterns.
  initial begin
    int  cyc;
    int  mode;
    bit  rdy;
    lamp_status_t got;
    cyc  = 0;
    mode = 0;
    status_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && status_ch.valid && status_ch.ready) begin
        got = {status_ch.left_lamp, status_ch.right_lamp, status_ch.hazard_active,
               status_ch.left_selected, status_ch.right_selected, status_ch.event_mask};
        tracker.compare_status(got);
      end
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
      end
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = (cyc % 4 == 3);
        default: rdy = ($urandom_range(0, 6) != 0);
      endcase
      status_ch.ready <= rdy;
      cyc++;
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(bit wr, logic [AddrW-1:0] addr, logic [DataW-1:0] wdata,
                          output logic [DataW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, read it back and update the prediction.
  task automatic write_reg(tihc_pkg::reg_idx_e idx, logic [CfgW-1:0] value);
    logic [DataW-1:0] rd;
    logic [AddrW-1:0] addr;
    addr = {idx, 2'b00};
    apb_xfer(1'b1, addr, DataW'(value), rd);
    apb_xfer(1'b0, addr, '0, rd);
    if (rd !== DataW'(value)) begin
      tracker.fail($sformatf("register %s read back %0h, wrote %0h", idx.name(), rd, value));
    end
    tracker.set_reg(idx, value);
  endtask

  task automatic configure(logic [CfgW-1:0] long_ms, logic [CfgW-1:0] blink_ms);
    write_reg(tihc_pkg::RegLongPress, long_ms);
    write_reg(tihc_pkg::RegBlinkInterval, blink_ms);
    settings++;
  endtask

  // Present one step and hold it until the transfer; bursts end in a random gap.
  task automatic send_step(bit left_down, bit right_down, logic [ElW-1:0] el);
    int gap;
    step_ch.valid         <= 1'b1;
    step_ch.left_pressed  <= left_down;
    step_ch.right_pressed <= right_down;
    step_ch.elapsed_ms    <= el;
    do @(posedge clk); while (!step_ch.ready);
    tracker.take_step(left_down, right_down, el);
    steps_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        step_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic hold_run(bit left_down, bit right_down, int n, int el_lo, int el_hi);
    repeat (n) send_step(left_down, right_down, ElW'($urandom_range(el_lo, el_hi)));
  endtask

  // Stop the step traffic and wait until every status item has come back.
  task automatic settle();
    step_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Random button sessions: mostly held presses of plausible length, some noise.
  task automatic run_random(int n, int el_lo, int el_hi);
    int target;
    int need;
    int len;
    target = steps_sent + n;
    need   = tracker.long_press_ms / ((el_lo + el_hi) / 2 + 1) + 2;
    while (steps_sent < target) begin
      len = $urandom_range(1, need + 3);
      case ($urandom_range(0, 9))
        0, 1, 2: hold_run(1'b1, 1'b0, len, el_lo, el_hi);
        3, 4, 5: hold_run(1'b0, 1'b1, len, el_lo, el_hi);
        6: hold_run(1'b1, 1'b1, len, el_lo, el_hi);
        7: begin
          hold_run(1'b1, 1'b0, 1, el_lo, el_hi);
          hold_run(1'b1, 1'b1, len, el_lo, el_hi);
        end
        8: hold_run(1'b0, 1'b0, $urandom_range(1, 3), el_lo, el_hi);
        default: begin
          repeat (len) begin
            send_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      ElW'($urandom_range(el_lo, el_hi)));
          end
        end
      endcase
    end
  endtask

  // Stimulus and final verdict.
  initial begin
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    step_ch.valid         <= 1'b0;
    step_ch.left_pressed  <= 1'b0;
    step_ch.right_pressed <= 1'b0;
    step_ch.elapsed_ms    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sessions at the reset thresholds: toggles, hazard on, and
    // a hazard clear that is re-armed in the same step.
    hold_run(1'b1, 1'b0, 5, 255, 255);
    send_step(1'b0, 1'b0, 8'd0);
    hold_run(1'b1, 1'b0, 5, 255, 255);
    hold_run(1'b0, 1'b1, 5, 255, 255);
    send_step(1'b0, 1'b0, 8'd0);
    hold_run(1'b1, 1'b1, 5, 255, 255);
    send_step(1'b0, 1'b0, 8'd0);
    hold_run(1'b1, 1'b1, 5, 255, 255);
    settle();

    // Smallest thresholds: a press acts once its hold is nonzero, the phase flips on every step with time elapsed.
    configure(16'd1, 16'd1);
    run_random(70, 0, 255);
    settle();

    // Largest thresholds: only a saturated hold and blink timer reach them.
    configure(16'hFFFF, 16'hFFFF);
    hold_run(1'b1, 1'b1, 262, 255, 255);
    send_step(1'b0, 1'b0, 8'd255);
    settle();

    configure(CfgW'($urandom_range(1, 1500)), CfgW'($urandom_range(1, 700)));
    run_random(90, 0, 255);
    settle();

    configure(CfgW'($urandom_range(1, 200)), CfgW'($urandom_range(1, 50)));
    run_random(90, 0, 31);
    settle();
    repeat (4) @(posedge clk);

    $display("Ran %0d button steps under %0d threshold settings.", steps_sent, settings);
    $display("Checked %0d status items, %0d mismatches.", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
